// File: hdl/stack_machine_execute_unit_macros.svh
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_macros
// assertion macros used by the execute unit
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define SMEU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("smeu assertion failed");
// checked at every edge, reset included
`define SMEU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("smeu assertion failed");
`else
`define SMEU_ASSERT(lbl, clk, rst_n, prop)
`define SMEU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hdl/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// types, sizes and helper functions of the stack machine execute unit
// ----------------------------------------------------------------------------
package smeu_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int MEM_WORDS   = 256;
  localparam int DATA_W      = 32;
  localparam int SW          = $clog2(STACK_DEPTH);
  localparam int CW          = $clog2(STACK_DEPTH + 1);
  localparam int MW          = $clog2(MEM_WORDS);

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_DUP   = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_MOD   = 4'd6,
    OP_SAY   = 4'd7,
    OP_END   = 4'd8,
    OP_JZ    = 4'd9,
    OP_JUMP  = 4'd10,
    OP_STORE = 4'd11,
    OP_LOAD  = 4'd12,
    OP_SWAP  = 4'd13
  } smeu_op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OVER  = 3'd1,
    ST_UNDER = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_END   = 3'd4,
    ST_IGN   = 3'd5
  } smeu_status_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } smeu_div_res_t;

  // word address modulo MEM_WORDS, one compare and subtract per bit
  function automatic logic [MW-1:0] mem_index(input logic [7:0] a);
    logic [31:0] v;
    v = 32'(a);
    for (int k = 7; k >= 0; k--) begin
      if (v >= (32'(MEM_WORDS) << k)) begin
        v = v - (32'(MEM_WORDS) << k);
      end
    end
    return MW'(v);
  endfunction

endpackage

// File: hdl/smeu_channels.sv
// ----------------------------------------------------------------------------
// smeu channels
// valid/ready channels for instructions and results
// ----------------------------------------------------------------------------
interface smeu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [31:0] operand;
  logic [7:0]  mem_address;

  modport source (output valid, operation, operand, mem_address, input ready);
  modport sink   (input valid, operation, operand, mem_address, output ready);
endinterface

interface smeu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        printed_valid;
  logic [31:0] printed_value;
  logic        branch_taken;
  logic [6:0]  stack_depth;

  modport source (output valid, status, printed_valid, printed_value, branch_taken,
                  stack_depth, input ready);
  modport sink   (input valid, status, printed_valid, printed_value, branch_taken,
                  stack_depth, output ready);
endinterface

// File: hdl/smeu_ram.sv
// ----------------------------------------------------------------------------
// smeu_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/smeu_divider.sv
// ----------------------------------------------------------------------------
// smeu_divider
// signed 32-bit divider, one quotient bit per cycle, truncating toward zero
// ----------------------------------------------------------------------------
module smeu_divider
  import smeu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output smeu_div_res_t     res
);

  localparam int IW = $clog2(DATA_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [IW-1:0]     iter_r, iter_nxt;
  logic [DATA_W:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;
  logic [DATA_W:0]   rem_sh;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    iter_nxt  = iter_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    rem_sh    = {rem_r[DATA_W-1:0], quo_r[DATA_W-1]};
    if (start) begin
      busy_nxt  = 1'b1;
      done_nxt  = 1'b0;
      iter_nxt  = '0;
      rem_nxt   = '0;
      quo_nxt   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_nxt   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_q_nxt = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r_nxt = dividend[DATA_W-1];
    end else if (busy_r) begin
      // restoring step
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      iter_nxt = iter_r + 1'b1;
      if (iter_r == IW'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r  <= iter_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  // sign fixup; the most negative quotient wraps onto itself
  assign res.busy      = busy_r;
  assign res.done      = done_r;
  assign res.quotient  = neg_q_r ? (~quo_r + 1'b1) : quo_r;
  assign res.remainder = neg_r_r ? (~rem_r[DATA_W-1:0] + 1'b1) : rem_r[DATA_W-1:0];

endmodule

// File: hdl/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// executes one stack machine instruction per transaction
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one instruction per transaction (operation, operand,
//   mem_address); out_ch returns exactly one result per instruction, in order.
//   the unit works on one instruction at a time: in_ch.ready is high only
//   while it is idle.
//   a result is written to the output register from execute; div and mod
//   first pass through the div and fin states, where the divider gives
//   one quotient bit per cycle.
//   the stack ram read of the entry below the top is registered; a new
//   instruction is taken only after the previous result is written.
//   the result sits in an output register; a stalled receiver holds the
//   instruction in execute or fin until the register frees up, nothing is dropped.
//   reset clears the stack count and the halt flag; stack and data memory
//   contents are not cleared and a load of a never stored word is undefined.
//   after end or an error every later instruction reports ignored.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_unit_macros.svh"

module stack_machine_execute_unit
  import smeu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  smeu_in_if.sink     in_ch,
  smeu_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              halted_r, halted_nxt;
  logic              out_valid_r, out_valid_nxt;

  // latched instruction
  smeu_op_t          op_r;
  logic [DATA_W-1:0] operand_r;
  logic [MW-1:0]     addr_r;

  // cached top of stack; the ram holds the entries below it
  logic [DATA_W-1:0] top_r, top_nxt;

  // result register
  smeu_status_t      status_r;
  logic              pv_r;
  logic [DATA_W-1:0] pval_r;
  logic              br_r;
  logic [6:0]        depth_r;

  logic              in_acc;
  logic              out_free;
  logic [1:0]        need;
  logic              grow;
  smeu_status_t      status_c;
  logic              div_go;
  logic              commit;
  logic              pv_c;
  logic              br_c;
  logic [DATA_W-1:0] a_val, b_val;
  logic [CW-1:0]     cnt_m1, cnt_m2;

  logic              stk_we;
  logic [SW-1:0]     stk_waddr;
  logic [DATA_W-1:0] stk_rdata;
  logic              dm_we;
  logic [MW-1:0]     dm_raddr;
  logic [DATA_W-1:0] dm_rdata;
  smeu_div_res_t     div_res;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign a_val    = top_r;
  assign b_val    = stk_rdata;
  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);

  // data memory read address follows the input while idle
  assign dm_raddr = (state_r == S_IDLE) ? mem_index(in_ch.mem_address) : addr_r;

  smeu_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (top_r),
    .raddr (cnt_m2[SW-1:0]),
    .rdata (stk_rdata)
  );

  smeu_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (addr_r),
    .wdata (a_val),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  smeu_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (b_val),
    .divisor  (a_val),
    .res      (div_res)
  );

  // operand needs and stack growth per operation
  always_comb begin
    need = 2'd0;
    grow = 1'b0;
    case (op_r)
      OP_PUSH, OP_LOAD:                           grow = 1'b1;
      OP_DUP: begin
        need = 2'd1;
        grow = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SWAP: need = 2'd2;
      OP_SAY, OP_JZ, OP_STORE:                    need = 2'd1;
      default:                                    need = 2'd0;
    endcase
  end

  // check order: halt, underflow, overflow, divide by zero, end
  always_comb begin
    priority if (halted_r) begin
      status_c = ST_IGN;
    end else if (count_r < CW'(need)) begin
      status_c = ST_UNDER;
    end else if (grow && (count_r >= CW'(STACK_DEPTH))) begin
      status_c = ST_OVER;
    end else if (((op_r == OP_DIV) || (op_r == OP_MOD)) && (a_val == '0)) begin
      status_c = ST_DIVZ;
    end else if (op_r == OP_END) begin
      status_c = ST_END;
    end else begin
      status_c = ST_OK;
    end
  end

  assign div_go = (state_r == S_EXEC) && (status_c == ST_OK)
                  && ((op_r == OP_DIV) || (op_r == OP_MOD));
  assign commit = out_free && (((state_r == S_EXEC) && !div_go) || (state_r == S_FIN));

  // stack and memory update at commit
  always_comb begin
    count_nxt  = count_r;
    top_nxt    = top_r;
    halted_nxt = halted_r;
    stk_we     = 1'b0;
    stk_waddr  = cnt_m1[SW-1:0];
    dm_we      = 1'b0;
    pv_c       = 1'b0;
    br_c       = 1'b0;
    if (commit) begin
      if (status_c != ST_OK) begin
        halted_nxt = 1'b1;
      end else begin
        case (op_r)
          OP_PUSH: begin
            stk_we    = (count_r != '0);
            top_nxt   = operand_r;
            count_nxt = count_r + CW'(1);
          end
          OP_DUP: begin
            stk_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          OP_ADD: begin
            top_nxt   = b_val + a_val;
            count_nxt = cnt_m1;
          end
          OP_SUB: begin
            top_nxt   = b_val - a_val;
            count_nxt = cnt_m1;
          end
          OP_MUL: begin
            top_nxt   = b_val * a_val;
            count_nxt = cnt_m1;
          end
          OP_DIV: begin
            top_nxt   = div_res.quotient;
            count_nxt = cnt_m1;
          end
          OP_MOD: begin
            top_nxt   = div_res.remainder;
            count_nxt = cnt_m1;
          end
          OP_SAY: begin
            pv_c      = 1'b1;
            top_nxt   = b_val;
            count_nxt = cnt_m1;
          end
          OP_JZ: begin
            // a zero top is consumed and the branch taken
            if (a_val == '0) begin
              br_c      = 1'b1;
              top_nxt   = b_val;
              count_nxt = cnt_m1;
            end
          end
          OP_JUMP: begin
            br_c = 1'b1;
          end
          OP_STORE: begin
            dm_we     = 1'b1;
            top_nxt   = b_val;
            count_nxt = cnt_m1;
          end
          OP_LOAD: begin
            stk_we    = (count_r != '0);
            top_nxt   = dm_rdata;
            count_nxt = count_r + CW'(1);
          end
          OP_SWAP: begin
            stk_we    = 1'b1;
            stk_waddr = cnt_m2[SW-1:0];
            top_nxt   = b_val;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_EXEC;
      S_EXEC: begin
        if (div_go) begin
          state_nxt = S_DIV;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV:  if (div_res.done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= smeu_op_t'(in_ch.operation);
      operand_r <= in_ch.operand;
      addr_r    <= mem_index(in_ch.mem_address);
    end
    top_r <= top_nxt;
    if (commit) begin
      status_r <= status_c;
      pv_r     <= pv_c;
      pval_r   <= pv_c ? a_val : '0;
      br_r     <= br_c;
      depth_r  <= 7'(count_nxt);
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.printed_valid = pv_r;
  assign out_ch.printed_value = pval_r;
  assign out_ch.branch_taken  = br_r;
  assign out_ch.stack_depth   = depth_r;

  `SMEU_ASSERT(a_depth_bound, clk, rst_n, count_r <= CW'(STACK_DEPTH))
  `SMEU_ASSERT(a_halt_sticky, clk, rst_n, halted_r |=> halted_r)
  `SMEU_ASSERT(a_ign_halted, clk, rst_n, (out_valid_r && (status_r == ST_IGN)) |-> halted_r)
  `SMEU_ASSERT(a_div_live, clk, rst_n, (state_r == S_DIV) |-> (div_res.busy || div_res.done))
  `SMEU_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE) && !out_valid_r)

endmodule

// File: verif/stack_machine_execute_unit_test.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_test
// self-checking bench: a class scoreboard predicts every instruction result,
// while random instruction streams run under several idle and stall patterns
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_test
  import smeu_pkg::*;
();

  // operation codes the package leaves unnamed
  localparam logic [3:0] OP_SPARE_A = 4'd14;
  localparam logic [3:0] OP_SPARE_B = 4'd15;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;

  // idle patterns
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  // ways to stop the machine at the end
  typedef enum int {HALT_END, HALT_UNDER, HALT_OVER, HALT_DIVZ} halt_kind_t;

  typedef struct {
    logic [3:0]  operation;
    logic [31:0] operand;
    logic [7:0]  mem_address;
  } instr_t;

  typedef struct {
    logic [2:0]  status;
    logic        printed_valid;
    logic [31:0] printed_value;
    logic        branch_taken;
    logic [6:0]  stack_depth;
  } outcome_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors stack, memory and halt flag
  // --------------------------------------------------------------------------
  class smeu_scoreboard;
    logic [31:0] stk [STACK_DEPTH];
    logic [31:0] mem [MEM_WORDS];
    int          depth;
    bit          halted;
    outcome_t    pending [$];
    int          errors;
    int          checked;
    int          prints;
    int          branches;

    function void push_word(logic [31:0] v);
      stk[depth % STACK_DEPTH] = v;
      depth++;
    endfunction

    // predict the outcome of one accepted instruction
    function void note(instr_t it);
      outcome_t    r;
      logic [31:0] a;
      logic [31:0] b;
      longint      q;
      int          need;
      bit          grow;
      r = '{status: ST_OK, printed_valid: 1'b0, printed_value: '0,
            branch_taken: 1'b0, stack_depth: '0};
      a = '0;
      b = '0;
      need = 0;
      grow = 0;
      if (halted) begin
        r.status = ST_IGN;
      end else begin
        case (it.operation)
          OP_PUSH, OP_LOAD: grow = 1;
          OP_DUP: begin
            need = 1;
            grow = 1;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SWAP: need = 2;
          OP_SAY, OP_JZ, OP_STORE: need = 1;
          default: ;
        endcase
        if (depth < need) begin
          r.status = ST_UNDER;
        end else if (grow && depth >= STACK_DEPTH) begin
          r.status = ST_OVER;
        end else begin
          if (need >= 1) a = stk[(depth - 1) % STACK_DEPTH];
          if (need >= 2) b = stk[(depth - 2) % STACK_DEPTH];
          if ((it.operation == OP_DIV || it.operation == OP_MOD) && a == 0) begin
            r.status = ST_DIVZ;
          end else begin
            depth -= need;
            case (it.operation)
              OP_PUSH: push_word(it.operand);
              OP_DUP: begin
                push_word(a);
                push_word(a);
              end
              OP_ADD: push_word(b + a);
              OP_SUB: push_word(b - a);
              OP_MUL: push_word(b * a);
              OP_DIV: begin
                q = longint'($signed(b)) / longint'($signed(a));
                push_word(q[31:0]);
              end
              OP_MOD: begin
                q = longint'($signed(b)) % longint'($signed(a));
                push_word(q[31:0]);
              end
              OP_SAY: begin
                r.printed_valid = 1'b1;
                r.printed_value = a;
              end
              OP_END: r.status = ST_END;
              OP_JZ: begin
                if (a != 0) push_word(a);
                else r.branch_taken = 1'b1;
              end
              OP_JUMP: r.branch_taken = 1'b1;
              OP_STORE: mem[it.mem_address % MEM_WORDS] = a;
              OP_LOAD: push_word(mem[it.mem_address % MEM_WORDS]);
              OP_SWAP: begin
                push_word(a);
                push_word(b);
              end
              default: ;
            endcase
          end
        end
        if (r.status != ST_OK) halted = 1;
      end
      r.stack_depth = depth[6:0];
      pending.push_back(r);
    endfunction

    // compare a result against the oldest prediction
    function void check(outcome_t o);
      outcome_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing pending: status %0d", o.status);
        return;
      end
      e = pending.pop_front();
      if (o.printed_valid === 1'b1) prints++;
      if (o.branch_taken === 1'b1) branches++;
      if (o.status !== e.status || o.printed_valid !== e.printed_valid ||
          o.printed_value !== e.printed_value || o.branch_taken !== e.branch_taken ||
          o.stack_depth !== e.stack_depth) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at result %0d: expected st %0d pv %0d val %h br %0d dep %0d",
                   checked, e.status, e.printed_valid, e.printed_value, e.branch_taken,
                   e.stack_depth);
          $display("                        actual   st %0d pv %0d val %h br %0d dep %0d",
                   o.status, o.printed_valid, o.printed_value, o.branch_taken,
                   o.stack_depth);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  smeu_in_if  in_ch ();
  smeu_out_if out_ch ();

  stack_machine_execute_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  smeu_scoreboard sb = new();

  // stimulus control, written by the sequencer with nonblocking assignments
  idle_mode_t idle_mode;
  halt_kind_t halt_kind;
  bit         halt_phase;
  bit         paused;
  bit         hold_req;
  int         rand_budget;
  int         ign_budget;

  // driver bookkeeping
  instr_t     cur;
  bit         have;
  int         n_rand;
  int         n_ign;
  int         n_acc;
  instr_t     directed [$];
  bit         written [MEM_WORDS];
  logic [7:0] written_list [$];
  int         hold_cnt;
  int         cycles;

  // clock, period 20
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // operand mix: zero, extremes, small values and wide random words
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(1, 20));
      default: return $urandom();
    endcase
  endfunction

  function automatic instr_t mk(logic [3:0] op, logic [31:0] v, logic [7:0] ad);
    instr_t it;
    it.operation = op;
    it.operand = v;
    it.mem_address = ad;
    return it;
  endfunction

  // random instruction that keeps the machine running
  function automatic instr_t gen_running();
    instr_t it;
    int     need;
    bit     grow;
    it = mk(4'($urandom_range(0, 15)), rand_word(), 8'($urandom()));
    if (it.operation == OP_END) it.operation = OP_PUSH;
    need = 0;
    grow = 0;
    case (it.operation)
      OP_PUSH, OP_LOAD: grow = 1;
      OP_DUP: begin
        need = 1;
        grow = 1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SWAP: need = 2;
      OP_SAY, OP_JZ, OP_STORE: need = 1;
      default: ;
    endcase
    if (sb.depth < need) begin
      it.operation = OP_PUSH;
    end else if (grow && sb.depth >= STACK_DEPTH) begin
      it.operation = OP_ADD;
    end else if ((it.operation == OP_DIV || it.operation == OP_MOD) &&
                 sb.stk[(sb.depth - 1) % STACK_DEPTH] == 0) begin
      it.operation = OP_SWAP;
    end else if (it.operation == OP_LOAD) begin
      // never load a word that was not stored
      if (written_list.size() == 0) it.operation = OP_PUSH;
      else it.mem_address = written_list[$urandom_range(0, written_list.size() - 1)];
    end
    return it;
  endfunction

  // instruction that drives toward the chosen halt
  function automatic instr_t gen_halting();
    instr_t it;
    it = mk(OP_PUSH, rand_word(), 8'($urandom()));
    if (sb.halted) begin
      // ignored afterwards; any code, loads included, reads nothing
      it.operation = 4'($urandom_range(0, 15));
      if (it.operation == OP_LOAD && written_list.size() != 0)
        it.mem_address = written_list[0];
      else if (it.operation == OP_LOAD)
        it.operation = OP_JUMP;
      return it;
    end
    case (halt_kind)
      HALT_END: it.operation = OP_END;
      HALT_UNDER: it.operation = OP_SAY;
      HALT_OVER: it.operation = OP_PUSH;
      default: begin
        if (sb.depth >= 2 && sb.stk[(sb.depth - 1) % STACK_DEPTH] == 0)
          it.operation = ($urandom_range(0, 1) != 0) ? OP_DIV : OP_MOD;
        else
          it.operand = 32'h0;
      end
    endcase
    return it;
  endfunction

  function automatic bit sender_idle();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 71;
      IDLE_BOTH: return $urandom_range(0, 99) < 21;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 71;
      IDLE_BOTH: return $urandom_range(0, 99) < 21;
      default: return 1'b0;
    endcase
  endfunction

  // instruction driver: hold each offer until its transaction completes
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      have = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note(cur);
        have = 1'b0;
        n_acc++;
      end
      if (!have && !paused && !sender_idle()) begin
        if (directed.size() != 0) begin
          cur = directed.pop_front();
          have = 1'b1;
        end else if (n_rand < rand_budget) begin
          cur = gen_running();
          n_rand++;
          have = 1'b1;
        end else if (halt_phase && n_ign < ign_budget) begin
          if (sb.halted) n_ign++;
          cur = gen_halting();
          have = 1'b1;
        end
        if (have && cur.operation == OP_STORE && !written[cur.mem_address]) begin
          written[cur.mem_address] = 1'b1;
          written_list.push_back(cur.mem_address);
        end
      end
      in_ch.valid <= have;
      in_ch.operation <= cur.operation;
      in_ch.operand <= cur.operand;
      in_ch.mem_address <= cur.mem_address;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // result monitor and receiver ready
  always @(posedge clk) begin
    outcome_t o;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        o.status = out_ch.status;
        o.printed_valid = out_ch.printed_valid;
        o.printed_value = out_ch.printed_value;
        o.branch_taken = out_ch.branch_taken;
        o.stack_depth = out_ch.stack_depth;
        sb.check(o);
      end
      out_ch.ready <= (hold_cnt == 0) && !receiver_stall();
    end
  end

  // run a random phase of n instructions under one idle pattern
  task automatic run_phase(idle_mode_t m, int n);
    idle_mode <= m;
    rand_budget <= rand_budget + n;
    @(posedge clk);
    while (n_rand < rand_budget || have) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (have || sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    // every input known from time zero
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.operand = '0;
    in_ch.mem_address = '0;
    out_ch.ready = 1'b0;
    idle_mode = IDLE_NONE;
    halt_kind = HALT_END;
    halt_phase = 1'b0;
    paused = 1'b0;
    hold_req = 1'b0;
    rand_budget = 0;
    ign_budget = 0;
    have = 1'b0;
    n_rand = 0;
    n_ign = 0;
    n_acc = 0;
    hold_cnt = 0;
    cycles = 0;
    foreach (written[k]) written[k] = 1'b0;
    sb.depth = 0;
    sb.halted = 0;

    // directed: wrap, min over minus one, operand order, memory extremes, jumps
    directed.push_back(mk(OP_PUSH, 32'h7fff_ffff, 8'h00));
    directed.push_back(mk(OP_PUSH, 32'h8000_0000, 8'hff));
    directed.push_back(mk(OP_PUSH, 32'hffff_ffff, 8'h00));
    directed.push_back(mk(OP_DIV, 32'h0, 8'h00));
    directed.push_back(mk(OP_PUSH, 32'hffff_ffff, 8'h00));
    directed.push_back(mk(OP_MOD, 32'h0, 8'h00));
    directed.push_back(mk(OP_ADD, 32'h0, 8'h00));
    directed.push_back(mk(OP_DUP, 32'h0, 8'h00));
    directed.push_back(mk(OP_ADD, 32'h0, 8'h00));
    directed.push_back(mk(OP_PUSH, 32'h8000_0000, 8'h00));
    directed.push_back(mk(OP_SUB, 32'h0, 8'h00));
    directed.push_back(mk(OP_DUP, 32'h0, 8'h00));
    directed.push_back(mk(OP_MUL, 32'h0, 8'h00));
    directed.push_back(mk(OP_PUSH, 32'd7, 8'h00));
    directed.push_back(mk(OP_SWAP, 32'h0, 8'h00));
    directed.push_back(mk(OP_STORE, 32'h0, 8'hff));
    directed.push_back(mk(OP_LOAD, 32'h0, 8'hff));
    directed.push_back(mk(OP_STORE, 32'h0, 8'h00));
    directed.push_back(mk(OP_LOAD, 32'h0, 8'h00));
    directed.push_back(mk(OP_SAY, 32'h0, 8'h00));
    directed.push_back(mk(OP_JZ, 32'h0, 8'h00));
    directed.push_back(mk(OP_PUSH, 32'h0, 8'h00));
    directed.push_back(mk(OP_JZ, 32'h0, 8'h00));
    directed.push_back(mk(OP_JUMP, 32'h0, 8'h00));
    directed.push_back(mk(OP_SPARE_A, 32'h0, 8'h00));
    directed.push_back(mk(OP_SPARE_B, 32'hffff_ffff, 8'hff));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (directed.size() != 0 || have) @(posedge clk);

    run_phase(IDLE_NONE, 150);

    // sender pause until every result is back
    run_phase(IDLE_SEND, 75);
    paused <= 1'b1;
    wait_drained();
    paused <= 1'b0;
    run_phase(IDLE_SEND, 75);

    // long receiver hold while offers keep coming
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_phase(IDLE_RECV, 150);

    run_phase(IDLE_BOTH, 150);
    run_phase(IDLE_NONE, 130);

    // stop the machine one way, then feed ignored instructions
    halt_kind <= halt_kind_t'($urandom_range(0, 3));
    ign_budget <= 12;
    halt_phase <= 1'b1;
    @(posedge clk);
    while (n_ign < ign_budget || have) @(posedge clk);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d instructions accepted, %0d results checked, %0d prints, %0d branches",
             n_acc, sb.checked, sb.prints, sb.branches);
    $display("idle patterns none/sender/receiver/both, halt kind %0d at the end", halt_kind);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d errors, %0d results outstanding", sb.errors, sb.pending.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/smeu_pkg.sv
hdl/smeu_channels.sv
hdl/smeu_ram.sv
hdl/smeu_divider.sv
hdl/stack_machine_execute_unit.sv
verif/stack_machine_execute_unit_test.sv
